>>> rtl/core/assert_macros.svh
// Assertion macros shared by the vector normalizer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define VN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication form of the above.
`define VN_ASSERT_IMP(label, ante, cons, msg) \
    `VN_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/core/vnorm_pkg.sv
// Package for the vector normalizer: widths, pipeline depths, payload type.
// Used by vnorm_sqrt, vnorm_div and vector_normalize.
`timescale 1ns / 1ps

package vnorm_pkg;

    localparam int COMP_W      = 16;
    localparam int NUM_COMP    = 4;
    localparam int UNIT_W      = 16;
    localparam int LEN_W       = 17;
    localparam int SQ_W        = 2 * COMP_W;
    localparam int SUM_W       = 2 * LEN_W;
    localparam int SQRT_STAGES = LEN_W;
    localparam int SQRT_REM_W  = LEN_W + 3;
    localparam int FRAC_BITS   = 14;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int DIV_REM_W   = LEN_W + 1;
    localparam int DIV_STAGES  = QUO_W;
    localparam int PAY_DEPTH   = SQRT_STAGES + DIV_STAGES;
    localparam int IN_TDATA_W  = NUM_COMP * COMP_W;
    localparam int OUT_TDATA_W = 88;
    localparam int W_IDX       = 3;

    typedef struct packed {
        logic                              valid;
        logic                              mode_four_d;
        logic [NUM_COMP-1:0][COMP_W-1:0]   comp;
    } payload_t;

endpackage

>>> rtl/core/vector_normalize.sv
// Vector normalizer top level: input staging, squares, sum, square root,
// four divider lanes and the merging output register.
// Depends on vnorm_pkg, vnorm_sqrt, vnorm_div and assert_macros.svh.
//
// Usage:
//   s_* takes one vector per request, x,y,z,w signed Q8.8 in s_tdata.
//   m_* gives one result per request: unit x,y,z,w in Q1.14 and the length
//   in Q8.8 in m_tdata, the zero-length flag in m_tuser.
//   cfg_* writes mode_four_d (bit 0 of cfg_data); cfg_ready is always high.
//   Write it only while the pipeline is empty.
// Pipeline: an accepted request passes the three staging registers,
//   17 square-root stages, 15 divider stages and the output register.
// Throughput: one vector per cycle if not stalled, every lane in parallel.
// Reset: clears every valid bit and sets mode_four_d to 1 (4D).
// Stall: when a result waits and m_tready is low the whole pipeline holds
//   and s_tready drops; it rises again in the cycle the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_normalize (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [0:0]                             cfg_data,     // mode_four_d
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // comp_x, comp_y, comp_z, comp_w
    input  logic [vnorm_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // unit_x, unit_y, unit_z, unit_w, vec_length, zero fill
    output logic [vnorm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                             m_tuser       // was_zero
);

    localparam int NC = vnorm_pkg::NUM_COMP;
    localparam int CW = vnorm_pkg::COMP_W;
    localparam int UW = vnorm_pkg::UNIT_W;
    localparam int LW = vnorm_pkg::LEN_W;
    localparam int QW = vnorm_pkg::QUO_W;
    localparam int PD = vnorm_pkg::PAY_DEPTH;
    localparam int SQ = vnorm_pkg::SQRT_STAGES;
    localparam int DS = vnorm_pkg::DIV_STAGES;

    logic                           ce;
    logic                           mode_reg;
    vnorm_pkg::payload_t            pa_reg, pb_reg, pc_reg;
    vnorm_pkg::payload_t            pay_reg [PD];
    logic [CW-1:0]                  mag_a_reg [NC];
    logic [vnorm_pkg::SQ_W-1:0]     sq_reg    [NC];
    logic [vnorm_pkg::SUM_W-1:0]    sum_reg;
    logic [LW-1:0]                  root;
    logic [LW-1:0]                  root_dly_reg [DS];
    logic [QW-1:0]                  quo [NC];
    logic [NC-1:0][UW-1:0]          unit_next;
    logic                           zero_next;
    logic                           m_tvalid_reg;
    logic [vnorm_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;

    assign ce        = !m_tvalid_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data[0];
        end
    end

    // stage A: capture, magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_reg.valid <= 1'b0;
        end else if (ce) begin
            pa_reg.valid <= s_tvalid;
        end
        if (ce) begin
            pa_reg.mode_four_d <= mode_reg;
            for (int i = 0; i < NC; i++) begin
                pa_reg.comp[i] <= s_tdata[i*CW +: CW];
                mag_a_reg[i]   <= s_tdata[i*CW + CW - 1] ? CW'(-s_tdata[i*CW +: CW])
                                                          : s_tdata[i*CW +: CW];
            end
        end
    end

    // stage B: squares, stage C: sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_reg.valid <= 1'b0;
            pc_reg.valid <= 1'b0;
        end else if (ce) begin
            pb_reg.valid <= pa_reg.valid;
            pc_reg.valid <= pb_reg.valid;
        end
        if (ce) begin
            pb_reg.mode_four_d <= pa_reg.mode_four_d;
            pb_reg.comp        <= pa_reg.comp;
            pc_reg.mode_four_d <= pb_reg.mode_four_d;
            pc_reg.comp        <= pb_reg.comp;
            for (int i = 0; i < NC; i++) begin
                sq_reg[i] <= mag_a_reg[i] * mag_a_reg[i];
            end
            // drop w from the sum in 3D mode
            sum_reg <= vnorm_pkg::SUM_W'(sq_reg[0]) + vnorm_pkg::SUM_W'(sq_reg[1])
                     + vnorm_pkg::SUM_W'(sq_reg[2])
                     + (pb_reg.mode_four_d ? vnorm_pkg::SUM_W'(sq_reg[3]) : '0);
        end
    end

    vnorm_sqrt u_sqrt (
        .aclk     (aclk),
        .ce       (ce),
        .radicand (sum_reg),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PD; i++) begin
                pay_reg[i].valid <= 1'b0;
            end
        end else if (ce) begin
            pay_reg[0].valid <= pc_reg.valid;
            for (int i = 1; i < PD; i++) begin
                pay_reg[i].valid <= pay_reg[i-1].valid;
            end
        end
        if (ce) begin
            pay_reg[0].mode_four_d <= pc_reg.mode_four_d;
            pay_reg[0].comp        <= pc_reg.comp;
            for (int i = 1; i < PD; i++) begin
                pay_reg[i].mode_four_d <= pay_reg[i-1].mode_four_d;
                pay_reg[i].comp        <= pay_reg[i-1].comp;
            end
            root_dly_reg[0] <= root;
            for (int i = 1; i < DS; i++) begin
                root_dly_reg[i] <= root_dly_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < NC; l++) begin : g_lane
        logic [CW-1:0] comp_d;
        logic [CW-1:0] mag_d;
        assign comp_d = pay_reg[SQ-1].comp[l];
        assign mag_d  = comp_d[CW-1] ? CW'(-comp_d) : comp_d;

        vnorm_div u_div (
            .aclk     (aclk),
            .ce       (ce),
            .mag      (mag_d),
            .divisor  (root),
            .quotient (quo[l])
        );
    end

    // merge: pick normalized or pass-through per component
    always_comb begin
        vnorm_pkg::payload_t p;
        logic [UW-1:0]       q_ext;
        p         = pay_reg[PD-1];
        zero_next = (root_dly_reg[DS-1] == '0);
        for (int i = 0; i < NC; i++) begin
            q_ext = {{(UW-QW){1'b0}}, quo[i]};
            if (zero_next || (i == vnorm_pkg::W_IDX && !p.mode_four_d)) begin
                unit_next[i] = UW'(p.comp[i]);
            end else if (p.comp[i][CW-1]) begin
                unit_next[i] = -q_ext;
            end else begin
                unit_next[i] = q_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= pay_reg[PD-1].valid;
        end
        if (ce) begin
            m_tdata_reg <= {{(vnorm_pkg::OUT_TDATA_W - NC*UW - LW){1'b0}},
                            root_dly_reg[DS-1], unit_next};
            m_tuser_reg <= zero_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `VN_ASSERT_IMP(a_zero_len, m_tvalid && m_tuser[0], m_tdata[80:64] == 17'd0,
        "zero flag with nonzero length")
    `VN_ASSERT_IMP(a_hold_input, m_tvalid && !m_tready, !s_tready,
        "input taken while result stalled")
    `VN_ASSERT_IMP(a_unit_range, m_tvalid && !m_tuser[0],
        ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384),
        "normalized x out of range")

endmodule

>>> rtl/core/vnorm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps

module vnorm_sqrt (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic [vnorm_pkg::SUM_W-1:0]     radicand,
    output logic [vnorm_pkg::LEN_W-1:0]     root
);

    localparam int N  = vnorm_pkg::SQRT_STAGES;
    localparam int SW = vnorm_pkg::SUM_W;
    localparam int RW = vnorm_pkg::SQRT_REM_W;
    localparam int LW = vnorm_pkg::LEN_W;

    logic [SW-1:0] rad_reg  [N];
    logic [RW-1:0] rem_reg  [N];
    logic [LW-1:0] root_reg [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [SW-1:0] rad_prev;
        logic [RW-1:0] rem_prev;
        logic [LW-1:0] root_prev;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic [SW-1:0] rad_next;
        logic [RW-1:0] rem_next;
        logic [LW-1:0] root_next;

        if (s == 0) begin : g_first
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_rest
            assign rad_prev  = rad_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
        end

        always_comb begin
            rem_sh   = {rem_prev[RW-3:0], rad_prev[SW-1 -: 2]};
            trial    = {{(RW-LW-2){1'b0}}, root_prev, 2'b01};
            rad_next = {rad_prev[SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[LW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_prev[LW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

>>> rtl/core/vnorm_div.sv
// One lane of the pipelined restoring divider: (mag << 14) / divisor.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps

module vnorm_div (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic [vnorm_pkg::COMP_W-1:0]    mag,
    input  logic [vnorm_pkg::LEN_W-1:0]     divisor,
    output logic [vnorm_pkg::QUO_W-1:0]     quotient
);

    localparam int N  = vnorm_pkg::DIV_STAGES;
    localparam int CW = vnorm_pkg::COMP_W;
    localparam int RW = vnorm_pkg::DIV_REM_W;
    localparam int LW = vnorm_pkg::LEN_W;
    localparam int QW = vnorm_pkg::QUO_W;
    localparam int FB = vnorm_pkg::FRAC_BITS;

    logic [RW-1:0] rem_reg [N];
    logic [QW-1:0] bits_reg[N];
    logic [QW-1:0] quo_reg [N];
    logic [LW-1:0] div_reg [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [RW-1:0] rem_prev;
        logic [QW-1:0] bits_prev;
        logic [QW-1:0] quo_prev;
        logic [LW-1:0] div_prev;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (s == 0) begin : g_first
            // upper numerator bits sit below the divisor: start the remainder there
            assign rem_prev  = {{(RW-CW+1){1'b0}}, mag[CW-1:1]};
            assign bits_prev = {mag[0], {FB{1'b0}}};
            assign quo_prev  = '0;
            assign div_prev  = divisor;
        end else begin : g_rest
            assign rem_prev  = rem_reg[s-1];
            assign bits_prev = bits_reg[s-1];
            assign quo_prev  = quo_reg[s-1];
            assign div_prev  = div_reg[s-1];
        end

        always_comb begin
            rem_sh = {rem_prev[RW-2:0], bits_prev[QW-1]};
            if (rem_sh >= {1'b0, div_prev}) begin
                rem_next = rem_sh - {1'b0, div_prev};
                quo_next = {quo_prev[QW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_prev[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s]  <= rem_next;
                bits_reg[s] <= {bits_prev[QW-2:0], 1'b0};
                quo_reg[s]  <= quo_next;
                div_reg[s]  <= div_prev;
            end
        end
    end

    assign quotient = quo_reg[N-1];

endmodule
